@@ hw/rtl/hkdq_pkg.sv @@
// ----------------------------------------------------------------------------
// hkdq_pkg: shared types and constants for the HID key decode queue
// Status codes, special key codes, the queued key record and the
// US-layout usage-to-character lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hkdq_pkg;

    // Result status codes
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_TAKEN   = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    // Special key codes
    localparam logic [3:0] SP_NONE  = 4'd0;
    localparam logic [3:0] SP_ENTER = 4'd1;
    localparam logic [3:0] SP_BKSP  = 4'd2;
    localparam logic [3:0] SP_ESC   = 4'd3;
    localparam logic [3:0] SP_TAB   = 4'd4;
    localparam logic [3:0] SP_DEL   = 4'd5;
    localparam logic [3:0] SP_RIGHT = 4'd6;
    localparam logic [3:0] SP_LEFT  = 4'd7;
    localparam logic [3:0] SP_DOWN  = 4'd8;
    localparam logic [3:0] SP_UP    = 4'd9;

    // Modifier masks, either side
    localparam logic [7:0] MOD_CTRL  = 8'h11;
    localparam logic [7:0] MOD_SHIFT = 8'h22;
    localparam logic [7:0] MOD_ALT   = 8'h44;

    // Usage code ranges
    localparam logic [7:0] UC_LETTER_LO = 8'h04;
    localparam logic [7:0] UC_LETTER_HI = 8'h1D;
    localparam logic [7:0] UC_DIGIT_LO  = 8'h1E;
    localparam logic [7:0] UC_DIGIT_HI  = 8'h27;

    localparam int KEY_W = 13;

    // Queued key record: char in bits 0-6, special 7-10, ctrl 11, alt 12
    typedef struct packed {
        logic       alt;
        logic       ctrl;
        logic [3:0] special;
        logic [6:0] chr;
    } t_key;

    // Decoder result handed to the queue control
    typedef struct packed {
        logic release_code;
        logic mapped;
        t_key key;
    } t_dec;

    function automatic logic [3:0] special_of(input logic [7:0] code);
        logic [3:0] sp;
        case (code)
            8'h28:   sp = SP_ENTER;
            8'h2A:   sp = SP_BKSP;
            8'h29:   sp = SP_ESC;
            8'h2B:   sp = SP_TAB;
            8'h4C:   sp = SP_DEL;
            8'h4F:   sp = SP_RIGHT;
            8'h50:   sp = SP_LEFT;
            8'h51:   sp = SP_DOWN;
            8'h52:   sp = SP_UP;
            default: sp = SP_NONE;
        endcase
        return sp;
    endfunction

    function automatic logic [6:0] char_of(input logic [7:0] code, input logic shift);
        logic [7:0] c;
        c = 8'd0;
        if (code inside {[UC_LETTER_LO:UC_LETTER_HI]}) begin
            c = 8'h61 + (code - UC_LETTER_LO);
            if (shift) begin
                c = c - 8'd32;
            end
        end else begin
            case (code)
                8'h1E:   c = shift ? 8'h21 : 8'h31; // ! 1
                8'h1F:   c = shift ? 8'h40 : 8'h32; // @ 2
                8'h20:   c = shift ? 8'h23 : 8'h33; // # 3
                8'h21:   c = shift ? 8'h24 : 8'h34; // $ 4
                8'h22:   c = shift ? 8'h25 : 8'h35; // % 5
                8'h23:   c = shift ? 8'h5E : 8'h36; // ^ 6
                8'h24:   c = shift ? 8'h26 : 8'h37; // & 7
                8'h25:   c = shift ? 8'h2A : 8'h38; // * 8
                8'h26:   c = shift ? 8'h28 : 8'h39; // ( 9
                8'h27:   c = shift ? 8'h29 : 8'h30; // ) 0
                8'h2C:   c = 8'h20;                 // space
                8'h2D:   c = shift ? 8'h5F : 8'h2D; // _ -
                8'h2E:   c = shift ? 8'h2B : 8'h3D; // + =
                8'h2F:   c = shift ? 8'h7B : 8'h5B; // { [
                8'h30:   c = shift ? 8'h7D : 8'h5D; // } ]
                8'h31:   c = shift ? 8'h7C : 8'h5C; // | backslash
                8'h33:   c = shift ? 8'h3A : 8'h3B; // : ;
                8'h34:   c = shift ? 8'h22 : 8'h27; // " '
                8'h35:   c = shift ? 8'h7E : 8'h60; // ~ `
                8'h36:   c = shift ? 8'h3C : 8'h2C; // < ,
                8'h37:   c = shift ? 8'h3E : 8'h2E; // > .
                8'h38:   c = shift ? 8'h3F : 8'h2F; // ? /
                default: c = 8'd0;                  // non-US hash and the rest
            endcase
        end
        return c[6:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hkdq_ram.sv @@
// ----------------------------------------------------------------------------
// hkdq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hkdq_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/hkdq_decode.sv @@
// ----------------------------------------------------------------------------
// hkdq_decode: HID usage and modifier decoder
// Map a page-7 usage code and modifier byte to a queued key record.
// ----------------------------------------------------------------------------
`default_nettype none

module hkdq_decode (
    input  wire logic [7:0]    i_modifier,
    input  wire logic [7:0]    i_usage_code,
    output hkdq_pkg::t_dec     o_dec
);

    logic       shift;
    logic [3:0] sp;
    logic [6:0] ch;

    always_comb begin
        shift = |(i_modifier & hkdq_pkg::MOD_SHIFT);
        sp    = hkdq_pkg::special_of(i_usage_code);
        // special keys win over the character map
        ch    = (sp == hkdq_pkg::SP_NONE) ? hkdq_pkg::char_of(i_usage_code, shift) : 7'd0;

        o_dec.release_code = (i_usage_code == 8'd0);
        o_dec.mapped       = (sp != hkdq_pkg::SP_NONE) || (ch != 7'd0);
        o_dec.key.alt      = |(i_modifier & hkdq_pkg::MOD_ALT);
        o_dec.key.ctrl     = |(i_modifier & hkdq_pkg::MOD_CTRL);
        o_dec.key.special  = sp;
        o_dec.key.chr      = ch;
    end

endmodule

`default_nettype wire

@@ hw/rtl/hid_key_decode_queue_unit.sv @@
// ----------------------------------------------------------------------------
// hid_key_decode_queue_unit: HID keyboard decoder with a ring key queue
// Decode keyboard event requests into keys, queue them, and pop them
// on take requests. One result per request.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports                  | Contents
//  --------+-----------+------------------------+---------------------------------
//  s       | in        | i_s_tvalid/o_s_tready  | tuser: cmd; tdata: modifier,
//          |           | i_s_tdata, i_s_tuser   |   usage_code
//  m       | out       | o_m_tvalid/i_m_tready  | tdata: status, key_char,
//          |           | o_m_tdata              |   key_special, key_ctrl, key_alt
//
//  Decode and pointer update happen at the accept edge, and the result is valid
//  on the next cycle. Throughput is one request per cycle while the output is
//  taken; the single result register sets that figure. The key store RAM read
//  is registered, so a popped key arrives alongside its status. Reset clears
//  the pointers and the result valid and holds the input off; the store holds
//  garbage until written. An output stall holds the input side off.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_key_decode_queue_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // [7:0] modifier, [15:8] usage_code
    input  wire logic        i_s_tuser,  // [0] cmd
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata   // [2:0] status, [9:3] key_char,
                                         // [13:10] key_special, [14] key_ctrl,
                                         // [15] key_alt
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    // Handshake
    logic in_acc;
    logic out_acc;

    // Queue pointers
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;

    // Result register
    logic       r_out_valid, n_out_valid;
    logic [2:0] r_out_status, n_out_status;

    // Decoder and store
    hkdq_pkg::t_dec dec;
    hkdq_pkg::t_key rd_key;
    logic [hkdq_pkg::KEY_W-1:0] rd_word;
    logic is_take;
    logic q_empty;
    logic q_full;
    logic push;
    logic pop;

    hkdq_decode u_decode (
        .i_modifier   (i_s_tdata[7:0]),
        .i_usage_code (i_s_tdata[15:8]),
        .o_dec        (dec)
    );

    // Advance the input whenever the result slot is free or being drained;
    // hold it off during reset
    assign o_s_tready = i_rst_n && (!r_out_valid || i_m_tready);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = r_out_valid && i_m_tready;

    assign is_take    = i_s_tuser;
    assign wr_ptr_inc = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
    assign rd_ptr_inc = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
    assign q_empty    = (r_wr_ptr == r_rd_ptr);
    // full at depth minus one: one slot always stays open
    assign q_full     = (wr_ptr_inc == r_rd_ptr);

    always_comb begin
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_out_valid  = r_out_valid && !out_acc;
        n_out_status = r_out_status;
        push         = 1'b0;
        pop          = 1'b0;
        if (in_acc) begin
            n_out_valid = 1'b1;
            if (is_take) begin
                if (q_empty) begin
                    n_out_status = hkdq_pkg::ST_EMPTY;
                end else begin
                    // pop the oldest key; the RAM read lands with the result
                    pop          = 1'b1;
                    n_rd_ptr     = rd_ptr_inc;
                    n_out_status = hkdq_pkg::ST_TAKEN;
                end
            end else if (dec.release_code || !dec.mapped) begin
                n_out_status = hkdq_pkg::ST_IGNORED;
            end else if (q_full) begin
                // drop the key, queue unchanged
                n_out_status = hkdq_pkg::ST_DROPPED;
            end else begin
                push         = 1'b1;
                n_wr_ptr     = wr_ptr_inc;
                n_out_status = hkdq_pkg::ST_STORED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
    end

    // Key store; read data only changes on a pop, so it holds through stalls
    hkdq_ram #(
        .WIDTH (hkdq_pkg::KEY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_wr_ptr),
        .i_wdata (dec.key),
        .i_re    (pop),
        .i_raddr (r_rd_ptr),
        .o_rdata (rd_word)
    );

    assign rd_key = hkdq_pkg::t_key'(rd_word);

    // Key fields are zero for every result but a taken key
    always_comb begin
        o_m_tdata[2:0] = r_out_status;
        if (r_out_status == hkdq_pkg::ST_TAKEN) begin
            o_m_tdata[9:3]   = rd_key.chr;
            o_m_tdata[13:10] = rd_key.special;
            o_m_tdata[14]    = rd_key.ctrl;
            o_m_tdata[15]    = rd_key.alt;
        end else begin
            o_m_tdata[15:3]  = '0;
        end
    end

    assign o_m_tvalid = r_out_valid;

    // Assertions
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_wr_ptr) < QUEUE_DEPTH) && (int'(r_rd_ptr) < QUEUE_DEPTH))
        else $error("queue pointer out of range");

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_take && !q_empty) |=> (r_out_status == hkdq_pkg::ST_TAKEN))
        else $error("take on non-empty queue did not report a key");

    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_take && q_full) |=> $stable(r_wr_ptr))
        else $error("write pointer moved while the queue was full");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && pop))
        else $error("push and pop in one cycle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule

`default_nettype wire

@@ tb/hid_key_decode_queue_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_key_decode_queue_unit_tb: self-checking bench for the HID key queue
// Streams keyboard event and take requests into the unit. It predicts every
// status and popped key with its own decoder and ring queue, and compares
// each result field by field. The sender runs in bursts, the receiver stalls
// in patterns, and one long receiver hold-off backs the unit up.
// ----------------------------------------------------------------------------

module hid_key_decode_queue_unit_tb;

    localparam int QUEUE_DEPTH   = 32;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int HOLD_OFF      = 400;   // long receiver stall, in cycles
    localparam int IDLE_LIMIT    = 4000;  // cycles without any handshake
    localparam int DRAIN_CYCLES  = 10;

    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_TAKE  = 1'b1;

    // Usage codes with a fixed meaning
    localparam logic [7:0] UC_RELEASE    = 8'h00;
    localparam logic [7:0] UC_ENTER      = 8'h28;
    localparam logic [7:0] UC_ESC        = 8'h29;
    localparam logic [7:0] UC_BKSP       = 8'h2A;
    localparam logic [7:0] UC_TAB        = 8'h2B;
    localparam logic [7:0] UC_DEL        = 8'h4C;
    localparam logic [7:0] UC_RIGHT      = 8'h4F;
    localparam logic [7:0] UC_LEFT       = 8'h50;
    localparam logic [7:0] UC_DOWN       = 8'h51;
    localparam logic [7:0] UC_UP         = 8'h52;
    localparam logic [7:0] UC_PUNCT_LO   = 8'h2C;
    localparam logic [7:0] UC_PUNCT_HI   = 8'h38;
    localparam logic [7:0] UC_NONUS_HASH = 8'h32;
    localparam logic [7:0] UC_CAPS_LOCK  = 8'h39;

    localparam logic [7:0] SPECIAL_CODES [9] = '{UC_ENTER, UC_BKSP, UC_ESC, UC_TAB,
                                                 UC_DEL, UC_RIGHT, UC_LEFT, UC_DOWN, UC_UP};

    localparam string DIGIT_PLAIN   = "1234567890";
    localparam string DIGIT_SHIFTED = "!@#$%^&*()";

    // Punctuation for 0x2C..0x38; the non-US hash slot holds zero (no mapping)
    localparam logic [7:0] PUNCT_PLAIN [13] = '{8'h20, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C,
                                               8'h00, 8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E,
                                               8'h2F};
    localparam logic [7:0] PUNCT_SHIFTED [13] = '{8'h20, 8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C,
                                                 8'h00, 8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E,
                                                 8'h3F};

    // One request as it travels on the slave side
    typedef struct packed {
        logic       cmd;
        logic [7:0] mods;
        logic [7:0] code;
    } t_request;

    // One result, laid out exactly as o_m_tdata
    typedef struct packed {
        logic       alt;
        logic       ctrl;
        logic [3:0] special;
        logic [6:0] chr;
        logic [2:0] status;
    } t_reply;

    // ------------------------------------------------------------------------
    // Key queue tracker: decodes each accepted request, keeps its own ring
    // queue, and holds the replies the unit still owes, oldest first.
    // ------------------------------------------------------------------------
    class key_queue_tracker;
        hkdq_pkg::t_key slots [QUEUE_DEPTH];
        int unsigned    wr_idx;
        int unsigned    rd_idx;
        t_reply         owed_replies [$];
        int unsigned    error_count;

        function logic [3:0] special_key(logic [7:0] code);
            case (code)
                UC_ENTER: return hkdq_pkg::SP_ENTER;
                UC_BKSP:  return hkdq_pkg::SP_BKSP;
                UC_ESC:   return hkdq_pkg::SP_ESC;
                UC_TAB:   return hkdq_pkg::SP_TAB;
                UC_DEL:   return hkdq_pkg::SP_DEL;
                UC_RIGHT: return hkdq_pkg::SP_RIGHT;
                UC_LEFT:  return hkdq_pkg::SP_LEFT;
                UC_DOWN:  return hkdq_pkg::SP_DOWN;
                UC_UP:    return hkdq_pkg::SP_UP;
                default:  return hkdq_pkg::SP_NONE;
            endcase
        endfunction

        function logic [6:0] usage_char(logic [7:0] code, logic shifted);
            logic [7:0] c;
            c = 8'h00;
            if (code inside {[hkdq_pkg::UC_LETTER_LO:hkdq_pkg::UC_LETTER_HI]}) begin
                c = (shifted ? 8'h41 : 8'h61) + (code - hkdq_pkg::UC_LETTER_LO);
            end else if (code inside {[hkdq_pkg::UC_DIGIT_LO:hkdq_pkg::UC_DIGIT_HI]}) begin
                c = shifted ? DIGIT_SHIFTED[code - hkdq_pkg::UC_DIGIT_LO]
                            : DIGIT_PLAIN[code - hkdq_pkg::UC_DIGIT_LO];
            end else if (code inside {[UC_PUNCT_LO:UC_PUNCT_HI]}) begin
                c = shifted ? PUNCT_SHIFTED[code - UC_PUNCT_LO] : PUNCT_PLAIN[code - UC_PUNCT_LO];
            end
            return c[6:0];
        endfunction

        function void note_request(t_request req);
            t_reply         r;
            hkdq_pkg::t_key k;
            int unsigned    nxt;
            r = '0;
            if (req.cmd == CMD_TAKE) begin
                if (wr_idx == rd_idx) begin
                    r.status = hkdq_pkg::ST_EMPTY;
                end else begin
                    k = slots[rd_idx];
                    rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
                    r.status  = hkdq_pkg::ST_TAKEN;
                    r.chr     = k.chr;
                    r.special = k.special;
                    r.ctrl    = k.ctrl;
                    r.alt     = k.alt;
                end
            end else begin
                // specials win over characters; GUI bits play no part
                k.special = special_key(req.code);
                k.chr     = (k.special == hkdq_pkg::SP_NONE) ?
                            usage_char(req.code, |(req.mods & hkdq_pkg::MOD_SHIFT)) : 7'd0;
                k.ctrl    = |(req.mods & hkdq_pkg::MOD_CTRL);
                k.alt     = |(req.mods & hkdq_pkg::MOD_ALT);
                nxt = (wr_idx + 1) % QUEUE_DEPTH;
                if (req.code == UC_RELEASE ||
                    (k.special == hkdq_pkg::SP_NONE && k.chr == 7'd0)) begin
                    r.status = hkdq_pkg::ST_IGNORED;
                end else if (nxt == rd_idx) begin
                    r.status = hkdq_pkg::ST_DROPPED;
                end else begin
                    slots[wr_idx] = k;
                    wr_idx = nxt;
                    r.status = hkdq_pkg::ST_STORED;
                end
            end
            owed_replies.push_back(r);
        endfunction

        function void check_result(t_reply got);
            t_reply want;
            if (owed_replies.size() == 0) begin
                $error("result %h arrived with no request outstanding", got);
                error_count++;
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                error_count++;
            end
            if (got.chr !== want.chr) begin
                $error("key_char: expected %h, got %h", want.chr, got.chr);
                error_count++;
            end
            if (got.special !== want.special) begin
                $error("key_special: expected %0d, got %0d", want.special, got.special);
                error_count++;
            end
            if (got.ctrl !== want.ctrl) begin
                $error("key_ctrl: expected %0d, got %0d", want.ctrl, got.ctrl);
                error_count++;
            end
            if (got.alt !== want.alt) begin
                $error("key_alt: expected %0d, got %0d", want.alt, got.alt);
                error_count++;
            end
        endfunction

        function int pending_count();
            return owed_replies.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // [7:0] modifier, [15:8] usage_code
    logic        i_s_tuser;   // [0] cmd
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [2:0] status, [9:3] key_char, [13:10] key_special,
                              // [14] key_ctrl, [15] key_alt

    key_queue_tracker tracker;
    t_request    request_list [$];
    int unsigned results_seen;
    int unsigned idle_cycles;

    hid_key_decode_queue_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    function automatic void push_request(logic cmd, logic [7:0] mods, logic [7:0] code);
        t_request req;
        req.cmd  = cmd;
        req.mods = mods;
        req.code = code;
        request_list.push_back(req);
    endfunction

    function automatic logic [7:0] pick_modifiers();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return hkdq_pkg::MOD_SHIFT & 8'($urandom);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Draw a code for a key: letters, digits, punctuation (its non-US hash decodes to nothing), specials
    function automatic logic [7:0] pick_key_code();
        case ($urandom_range(0, 8))
            0, 1, 2: return 8'($urandom_range(hkdq_pkg::UC_LETTER_LO, hkdq_pkg::UC_LETTER_HI));
            3, 4:    return 8'($urandom_range(hkdq_pkg::UC_DIGIT_LO, hkdq_pkg::UC_DIGIT_HI));
            5, 6:    return 8'($urandom_range(UC_PUNCT_LO, UC_PUNCT_HI));
            default: return SPECIAL_CODES[$urandom_range(0, 8)];
        endcase
    endfunction

    // Append one request; return the number of requests appended
    function automatic int add_request(int take_pct, int noise_pct);
        if ($urandom_range(0, 99) < take_pct) begin
            push_request(CMD_TAKE, 8'($urandom), 8'($urandom));
            return 1;
        end
        if ($urandom_range(0, 99) < noise_pct) begin
            push_request(CMD_EVENT, 8'($urandom),
                         ($urandom_range(0, 4) == 0) ? UC_RELEASE : 8'($urandom));
            return 1;
        end
        push_request(CMD_EVENT, pick_modifiers(), pick_key_code());
        return 1;
    endfunction

    function automatic void build_directed();
        push_request(CMD_TAKE,  8'hFF, 8'hFF);          // take on an empty queue
        push_request(CMD_EVENT, 8'hFF, UC_RELEASE);     // release, every modifier
        push_request(CMD_EVENT, 8'h00, UC_NONUS_HASH);  // no US mapping
        push_request(CMD_EVENT, 8'h22, UC_CAPS_LOCK);   // unmapped code
        push_request(CMD_EVENT, 8'h00, 8'hFF);          // top of the code range
        push_request(CMD_EVENT, 8'h00, hkdq_pkg::UC_LETTER_LO);   // 'a'
        push_request(CMD_EVENT, 8'h20, hkdq_pkg::UC_LETTER_HI);   // right shift: 'Z'
        push_request(CMD_EVENT, 8'h88, 8'h10);          // GUI keys only: 'm'
        push_request(CMD_EVENT, 8'h02, hkdq_pkg::UC_DIGIT_LO);    // '!'
        push_request(CMD_EVENT, 8'h00, hkdq_pkg::UC_DIGIT_HI);    // '0'
        push_request(CMD_EVENT, 8'h22, UC_PUNCT_LO);    // space ignores shift
        push_request(CMD_EVENT, 8'h02, 8'h31);          // '|'
        push_request(CMD_EVENT, 8'h00, UC_PUNCT_HI);    // '/'
        // specials with assorted ctrl and alt from either side
        push_request(CMD_EVENT, 8'h01, UC_ENTER);
        push_request(CMD_EVENT, 8'h10, UC_BKSP);
        push_request(CMD_EVENT, 8'h04, UC_ESC);
        push_request(CMD_EVENT, 8'h40, UC_TAB);
        push_request(CMD_EVENT, 8'h55, UC_DEL);
        push_request(CMD_EVENT, 8'h00, UC_RIGHT);
        push_request(CMD_EVENT, 8'hFF, UC_LEFT);
        push_request(CMD_EVENT, 8'h22, UC_DOWN);
        push_request(CMD_EVENT, 8'h11, UC_UP);
        repeat (3) push_request(CMD_TAKE, 8'h00, 8'h00);
    endfunction

    // Alternate fill, drain, mixed and noise phases so the queue both
    // overflows and runs dry, and the pointers wrap many times
    function automatic void build_random();
        int counted;
        int phase;
        int n;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            phase = $urandom_range(0, 3);
            n = $urandom_range(20, 60);
            repeat (n) begin
                case (phase)
                    0:       counted += add_request(5, 10);
                    1:       counted += add_request(85, 10);
                    2:       counted += add_request(50, 30);
                    default: counted += add_request(30, 90);
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer requests in bursts, hold each until it is accepted
    // ------------------------------------------------------------------------
    task automatic send_requests();
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < request_list.size()) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
            while (burst > 0 && sent < request_list.size()) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= request_list[sent].cmd;
                i_s_tdata  <= {request_list[sent].code, request_list[sent].mods};
                do @(posedge i_clk); while (!o_s_tready);
                sent++;
                burst--;
            end
            // some bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall in stretches of its own; once, hold off long enough
    // that the result register backs up and the input side stalls
    // ------------------------------------------------------------------------
    initial begin : receiver
        int  mode;
        int  span;
        int  k;
        bit  held_off;
        held_off = 1'b0;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held_off && results_seen >= 300) begin
                held_off = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(5, 80);
                for (k = 0; k < span; k++) begin
                    case (mode)
                        0:       i_m_tready <= 1'b1;
                        1:       i_m_tready <= ($urandom_range(0, 1) == 1);
                        2:       i_m_tready <= (k % 3 != 0);
                        default: i_m_tready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results before noting new requests, so a result can
    // never be matched against a request accepted at the same edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                tracker.check_result(t_reply'(o_m_tdata));
                results_seen++;
            end
            if (i_s_tvalid && o_s_tready) begin
                tracker.note_request({i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8]});
            end
        end
    end

    // Watchdog: end the run when neither side moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("hid_key_decode_queue_unit_tb failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, stream all requests, drain, report
    // ------------------------------------------------------------------------
    initial begin
        tracker      = new();
        results_seen = 0;
        idle_cycles  = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= CMD_EVENT;
        i_s_tdata  <= '0;
        build_directed();
        build_random();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_requests();
        // wait for every owed result, then watch for strays
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.error_count == 0 && tracker.pending_count() == 0) begin
            $display("hid_key_decode_queue_unit_tb passed");
        end else begin
            $display("hid_key_decode_queue_unit_tb failed");
        end
        $finish;
    end

endmodule
